// ===== rtl/dpf_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dpf_pkg
// Types, codes and helpers shared by the DPD pair force block.
// ---------------------------------------------------------------------------
package dpf_pkg;

    localparam int DEF_ATOM_COUNT   = 1024;
    localparam int DEF_RANDOM_SLOTS = 16;
    localparam int DEF_FRAC_BITS    = 16;

    localparam logic [29:0] INV_SQRT2_Q30 = 30'd759250125;

    localparam logic [2:0] REG_FRICTION  = 3'd0;
    localparam logic [2:0] REG_BOLTZMANN = 3'd1;
    localparam logic [2:0] REG_TEMP      = 3'd2;
    localparam logic [2:0] REG_TIME_STEP = 3'd3;
    localparam logic [2:0] REG_CUTOFF    = 3'd4;
    localparam logic [2:0] REG_OFFSET    = 3'd5;

    localparam logic RK_PAIR = 1'b0;
    localparam logic RK_READ = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD_VEL   = 2'd0,
        ACT_LOAD_NOISE = 2'd1,
        ACT_PAIR       = 2'd2,
        ACT_READ_CLEAR = 2'd3
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [9:0]         first_atom;
        logic [9:0]         second_atom;
        logic [3:0]         random_slot;
        logic [30:0]        squared_distance;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
    } in_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } out_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_MUL1, ST_MUL2, ST_DIV_AMP, ST_AMP_PREP, ST_SQRT_AMP,
        ST_DIST_PREP, ST_SQRT_DIST, ST_RATIO_PREP, ST_DIV_RATIO, ST_CHI, ST_SQR,
        ST_AC, ST_FR, ST_VI, ST_VJ, ST_NI, ST_NJ, ST_W, ST_T1, ST_T2, ST_FS,
        ST_ACC_IA, ST_ACC_I, ST_ACC_JA, ST_ACC_J, ST_RC_A, ST_RC_D, ST_EMIT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
        if (x > 65'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (x < -65'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic [30:0] usat31(input logic [63:0] x);
        return (x > 64'h7fffffff) ? 31'h7fffffff : x[30:0];
    endfunction

    function automatic logic [31:0] axis_sel(input logic [95:0] w, input logic [1:0] a);
        case (a)
            2'd0:    return w[31:0];
            2'd1:    return w[63:32];
            default: return w[95:64];
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dpd_pair_force.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dpd_pair_force
// A load is written at its accepting edge. A read-and-clear result passes the
// RC_A, RC_D and EMIT states; a pair result is set by the shared iterative
// divide and square root steps (two 64-step divisions, two 32-step square
// roots) and a pass per axis through the NI, NJ, W, T1, T2 and FS states. One
// item at a time: the next item is accepted only while the block is idle, and
// a result waits in EMIT while the output register holds an untaken result.
// After reset a clearing pass zeroes the force accumulators, one per atom; no
// item is accepted until it ends.
// ---------------------------------------------------------------------------
module dpd_pair_force
    import dpf_pkg::*;
#(
    parameter int ATOM_COUNT   = DEF_ATOM_COUNT,
    parameter int RANDOM_SLOTS = DEF_RANDOM_SLOTS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data
);

    localparam int AW     = $clog2(ATOM_COUNT);
    localparam int SW     = $clog2(RANDOM_SLOTS);
    localparam int NDEPTH = ATOM_COUNT * RANDOM_SLOTS;
    localparam int NAW    = $clog2(NDEPTH);

    function automatic logic [AW-1:0] atom_mod(input logic [9:0] v);
        logic [31:0] rem;
        rem = 32'(v);
        for (int s = 9; s >= 0; s--) begin
            if (rem >= (32'(ATOM_COUNT) << s)) begin
                rem = rem - (32'(ATOM_COUNT) << s);
            end
        end
        return rem[AW-1:0];
    endfunction

    function automatic logic [SW-1:0] slot_mod(input logic [17:0] v);
        logic [31:0] rem;
        rem = 32'(v);
        for (int s = 17; s >= 0; s--) begin
            if (rem >= (32'(RANDOM_SLOTS) << s)) begin
                rem = rem - (32'(RANDOM_SLOTS) << s);
            end
        end
        return rem[SW-1:0];
    endfunction

    function automatic logic [NAW-1:0] naddr(input logic [AW-1:0] a, input logic [SW-1:0] k);
        return NAW'(a) * NAW'(RANDOM_SLOTS) + NAW'(k);
    endfunction

    // configuration
    logic [30:0] friction_reg, kb_reg, temp_reg, dt_reg, rc_reg;
    logic [15:0] offset_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            friction_reg <= 31'd65536;
            kb_reg       <= 31'd65536;
            temp_reg     <= 31'd65536;
            dt_reg       <= 31'd655;
            rc_reg       <= 31'd65536;
            offset_reg   <= 16'd0;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_FRICTION:  friction_reg <= pwdata[30:0];
                REG_BOLTZMANN: kb_reg       <= pwdata[30:0];
                REG_TEMP:      temp_reg     <= pwdata[30:0];
                REG_TIME_STEP: dt_reg       <= pwdata[30:0];
                REG_CUTOFF:    rc_reg       <= pwdata[30:0];
                REG_OFFSET:    offset_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_FRICTION:  prdata = {1'b0, friction_reg};
            REG_BOLTZMANN: prdata = {1'b0, kb_reg};
            REG_TEMP:      prdata = {1'b0, temp_reg};
            REG_TIME_STEP: prdata = {1'b0, dt_reg};
            REG_CUTOFF:    prdata = {1'b0, rc_reg};
            REG_OFFSET:    prdata = {16'd0, offset_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // memories
    logic           vel_we, noise_we, acc_we;
    logic [AW-1:0]  vel_waddr, vel_raddr, acc_waddr, acc_raddr;
    logic [NAW-1:0] noise_waddr, noise_raddr;
    logic [95:0]    vel_wdata, noise_wdata, acc_wdata;
    logic [95:0]    vel_rdata, noise_rdata, acc_rdata;

    dpf_ram #(.WIDTH(96), .DEPTH(ATOM_COUNT)) u_vel_ram (
        .aclk(aclk), .we(vel_we), .waddr(vel_waddr), .wdata(vel_wdata),
        .raddr(vel_raddr), .rdata(vel_rdata)
    );

    dpf_ram #(.WIDTH(96), .DEPTH(NDEPTH)) u_noise_ram (
        .aclk(aclk), .we(noise_we), .waddr(noise_waddr), .wdata(noise_wdata),
        .raddr(noise_raddr), .rdata(noise_rdata)
    );

    dpf_ram #(.WIDTH(96), .DEPTH(ATOM_COUNT)) u_acc_ram (
        .aclk(aclk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
        .raddr(acc_raddr), .rdata(acc_rdata)
    );

    // control and datapath registers
    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg;
    logic [5:0]         cnt_reg;
    logic [1:0]         axis_reg;
    logic [SW-1:0]      k_reg;
    logic [AW-1:0]      ai_reg, aj_reg;
    logic [30:0]        d2_reg, tmp_reg, amp_reg, chi2_reg, fr_reg, dvs_reg, rem_reg;
    logic [63:0]        num_reg, sv_reg, root_reg;
    logic signed [31:0] chi_reg, ac_reg, ni_reg, w_reg, dv_reg;
    logic signed [63:0] t1_reg, t2_reg;
    logic [95:0]        vi_reg, vj_reg;
    logic signed [31:0] f_reg [3];
    logic               kind_reg;
    logic               m_valid_reg;
    out_t               m_data_reg;
    logic               accept, emit;

    assign accept = s_valid & s_ready;

    // shared divide step
    logic [31:0] div_sh;
    logic        div_ge;
    logic [30:0] div_rem;
    logic [63:0] div_num;

    assign div_sh  = {rem_reg, num_reg[63]};
    assign div_ge  = div_sh >= {1'b0, dvs_reg};
    assign div_rem = div_ge ? 31'(div_sh - {1'b0, dvs_reg}) : div_sh[30:0];
    assign div_num = {num_reg[62:0], div_ge};

    // shared square root step
    logic [63:0] sq_bit, sq_trial;
    logic        sq_ge;

    assign sq_bit   = 64'd1 << (6'd62 - {cnt_reg[4:0], 1'b0});
    assign sq_trial = root_reg + sq_bit;
    assign sq_ge    = sv_reg >= sq_trial;

    // arithmetic
    logic [63:0]        p_u1, p_u2, p_sq, p_fr, amp_lim;
    logic [31:0]        mag;
    logic signed [63:0] p_ac, p_t1, p_t2, p_w;
    logic signed [31:0] nj_sel, vi_sel, vj_sel;
    logic signed [32:0] w_sum;
    logic signed [31:0] acc_x, acc_y, acc_z;

    assign p_u1    = 64'(friction_reg) * 64'(kb_reg);
    assign p_u2    = 64'(tmp_reg) * 64'(temp_reg);
    assign mag     = chi_reg[31] ? 32'(-chi_reg) : chi_reg;
    assign p_sq    = 64'(mag) * 64'(mag);
    assign p_fr    = 64'(friction_reg) * 64'(chi2_reg);
    assign amp_lim = 64'hffff_ffff_ffff_ffff >> FRAC_BITS;
    assign p_ac    = $signed(64'(amp_reg)) * 64'(chi_reg);
    assign nj_sel  = axis_sel(noise_rdata, axis_reg);
    assign vi_sel  = axis_sel(vi_reg, axis_reg);
    assign vj_sel  = axis_sel(vj_reg, axis_reg);
    assign w_sum   = 33'(ni_reg) + 33'(nj_sel);
    assign p_w     = 64'(w_sum) * $signed(64'(INV_SQRT2_Q30));
    assign p_t1    = $signed(64'(fr_reg)) * 64'(dv_reg);
    assign p_t2    = 64'(ac_reg) * 64'(w_reg);
    assign acc_x   = acc_rdata[31:0];
    assign acc_y   = acc_rdata[63:32];
    assign acc_z   = acc_rdata[95:64];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        emit        = 1'b0;
        vel_we      = 1'b0;
        vel_waddr   = atom_mod(s_data.first_atom);
        vel_wdata   = {s_data.value_z, s_data.value_y, s_data.value_x};
        vel_raddr   = aj_reg;
        noise_we    = 1'b0;
        noise_waddr = naddr(atom_mod(s_data.first_atom),
                            slot_mod(18'(s_data.random_slot)));
        noise_wdata = {s_data.value_z, s_data.value_y, s_data.value_x};
        noise_raddr = naddr(aj_reg, k_reg);
        acc_we      = 1'b0;
        acc_waddr   = ai_reg;
        acc_wdata   = '0;
        acc_raddr   = ai_reg;
        case (state_reg)
            ST_CLEAR: begin
                acc_we    = 1'b1;
                acc_waddr = clr_reg;
                if (clr_reg == AW'(ATOM_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    case (s_data.action)
                        ACT_LOAD_VEL:   vel_we = 1'b1;
                        ACT_LOAD_NOISE: noise_we = 1'b1;
                        ACT_PAIR:       state_next = ST_MUL1;
                        ACT_READ_CLEAR: state_next = ST_RC_A;
                        default: ;
                    endcase
                end
            end
            ST_MUL1:       state_next = ST_MUL2;
            ST_MUL2:       state_next = ST_DIV_AMP;
            ST_DIV_AMP:    if (cnt_reg == 6'd63) state_next = ST_AMP_PREP;
            ST_AMP_PREP:   state_next = ST_SQRT_AMP;
            ST_SQRT_AMP:   if (cnt_reg == 6'd31) state_next = ST_DIST_PREP;
            ST_DIST_PREP:  state_next = ST_SQRT_DIST;
            ST_SQRT_DIST:  if (cnt_reg == 6'd31) state_next = ST_RATIO_PREP;
            ST_RATIO_PREP: state_next = ST_DIV_RATIO;
            ST_DIV_RATIO:  if (cnt_reg == 6'd63) state_next = ST_CHI;
            ST_CHI:        state_next = ST_SQR;
            ST_SQR:        state_next = ST_AC;
            ST_AC:         state_next = ST_FR;
            ST_FR:         state_next = ST_VI;
            ST_VI: begin
                vel_raddr  = ai_reg;
                state_next = ST_VJ;
            end
            ST_VJ:         state_next = ST_NI;
            ST_NI: begin
                noise_raddr = naddr(ai_reg, k_reg);
                state_next  = ST_NJ;
            end
            ST_NJ:         state_next = ST_W;
            ST_W:          state_next = ST_T1;
            ST_T1:         state_next = ST_T2;
            ST_T2:         state_next = ST_FS;
            ST_FS:         state_next = (axis_reg == 2'd2) ? ST_ACC_IA : ST_NI;
            ST_ACC_IA:     state_next = ST_ACC_I;
            ST_ACC_I: begin
                acc_we     = 1'b1;
                acc_wdata  = {sat32(65'(acc_z) + 65'(f_reg[2])),
                              sat32(65'(acc_y) + 65'(f_reg[1])),
                              sat32(65'(acc_x) + 65'(f_reg[0]))};
                state_next = ST_ACC_JA;
            end
            ST_ACC_JA: begin
                acc_raddr  = aj_reg;
                state_next = ST_ACC_J;
            end
            ST_ACC_J: begin
                acc_we     = 1'b1;
                acc_waddr  = aj_reg;
                acc_wdata  = {sat32(65'(acc_z) - 65'(f_reg[2])),
                              sat32(65'(acc_y) - 65'(f_reg[1])),
                              sat32(65'(acc_x) - 65'(f_reg[0]))};
                state_next = ST_EMIT;
            end
            ST_RC_A:       state_next = ST_RC_D;
            ST_RC_D: begin
                acc_we     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (state_reg == ST_CLEAR) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                ai_reg   <= atom_mod(s_data.first_atom);
                aj_reg   <= atom_mod(s_data.second_atom);
                d2_reg   <= s_data.squared_distance;
                axis_reg <= 2'd0;
            end
            ST_MUL1: begin
                tmp_reg <= usat31(p_u1 >> FRAC_BITS);
                k_reg   <= slot_mod(18'(offset_reg) + 18'(ai_reg) + 18'(aj_reg) + 18'd1);
            end
            ST_MUL2: begin
                num_reg <= 64'(usat31(p_u2 >> FRAC_BITS)) << (FRAC_BITS + 1);
                rem_reg <= '0;
                cnt_reg <= '0;
                dvs_reg <= (dt_reg == 31'd0) ? 31'd1 : dt_reg;
            end
            ST_DIV_AMP, ST_DIV_RATIO: begin
                num_reg <= div_num;
                rem_reg <= div_rem;
                cnt_reg <= cnt_reg + 6'd1;
            end
            ST_AMP_PREP: begin
                sv_reg   <= (num_reg > amp_lim) ? 64'hffff_ffff_ffff_ffff
                                                : (num_reg << FRAC_BITS);
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_SQRT_AMP, ST_SQRT_DIST: begin
                if (sq_ge) begin
                    sv_reg   <= sv_reg - sq_trial;
                    root_reg <= (root_reg >> 1) + sq_bit;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            ST_DIST_PREP: begin
                amp_reg  <= usat31(root_reg);
                sv_reg   <= 64'(d2_reg) << FRAC_BITS;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_RATIO_PREP: begin
                num_reg <= root_reg << FRAC_BITS;
                rem_reg <= '0;
                cnt_reg <= '0;
                dvs_reg <= (rc_reg == 31'd0) ? 31'd1 : rc_reg;
            end
            ST_CHI: begin
                chi_reg <= sat32($signed(65'(64'd1 << FRAC_BITS)) - $signed({1'b0, num_reg}));
            end
            ST_SQR: chi2_reg <= usat31(p_sq >> FRAC_BITS);
            ST_AC:  ac_reg   <= sat32(65'(p_ac >>> FRAC_BITS));
            ST_FR:  fr_reg   <= usat31(p_fr >> FRAC_BITS);
            ST_VJ:  vi_reg   <= vel_rdata;
            ST_NI: begin
                if (axis_reg == 2'd0) begin
                    vj_reg <= vel_rdata;
                end
            end
            ST_NJ:  ni_reg <= axis_sel(noise_rdata, axis_reg);
            ST_W: begin
                w_reg  <= sat32(65'(p_w >>> 30));
                dv_reg <= sat32(65'(vi_sel) - 65'(vj_sel));
            end
            ST_T1:  t1_reg <= -(p_t1 >>> FRAC_BITS);
            ST_T2:  t2_reg <= p_t2 >>> FRAC_BITS;
            ST_FS: begin
                f_reg[axis_reg] <= sat32(65'(t1_reg) + 65'(t2_reg));
                axis_reg        <= axis_reg + 2'd1;
                k_reg           <= (k_reg == SW'(RANDOM_SLOTS - 1)) ? '0 : k_reg + 1'b1;
            end
            ST_ACC_J: kind_reg <= RK_PAIR;
            ST_RC_D: begin
                f_reg[0] <= acc_x;
                f_reg[1] <= acc_y;
                f_reg[2] <= acc_z;
                kind_reg <= RK_READ;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg.result_kind <= kind_reg;
            m_data_reg.force_x     <= f_reg[0];
            m_data_reg.force_y     <= f_reg[1];
            m_data_reg.force_z     <= f_reg[2];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== rtl/dpf_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dpf_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module dpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire
